### rtl/ecsw_pkg.sv
package ecsw_pkg;

   localparam int TOTAL_W  = 38;
   localparam int BUCKET_W = 32;
   localparam int COUNT_W  = 31;
   localparam int TICK_W   = 8;
   localparam int PADDR_W  = 3;
   localparam int PDATA_W  = 32;

   localparam logic [TICK_W-1:0] TICKS_PER_BUCKET_RESET = 8'd30;

   // Item kinds.
   localparam logic KIND_TICK    = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   // Register word indexes (byte address divided by four).
   localparam logic [PADDR_W-3:0] REG_TICKS_PER_BUCKET = 1'b0;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] device_count;
   } req_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] window_total;
      logic               bucket_advanced;
   } rsp_type;

   typedef struct packed {
      logic [TICK_W-1:0] ticks_per_bucket;
   } cfg_type;

endpackage

### rtl/event_count_sliding_window_core.sv
// Sliding-window event counter. Each transaction on the req_ channel is either a tick carrying
// a cumulative event count or a restart; every one yields exactly one rsp_ transaction with
// the window total (sum of BUCKETS buckets, each saturating at 2^32-1) and a flag that the
// tick moved to a new bucket. The block takes one transaction per clock cycle unless a full
// result register is held by rsp_ready being low; a request is held in the input register
// and its result then in the result register until rsp_ready takes it. The active bucket lives
// in a register, the other buckets in a single-port-write RAM whose next entry is read ahead
// every cycle, which is what lets the ring advance without a stall. Restart clears the window.
module event_count_sliding_window_core #(
   parameter int BUCKETS = 60
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ecsw_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ecsw_pkg::rsp_type             rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ecsw_pkg::PADDR_W-1:0]  paddr,
   input  logic [ecsw_pkg::PDATA_W-1:0]  pwdata,
   output logic [ecsw_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready
);

   logic              in_valid_ff, in_valid_in;
   ecsw_pkg::req_type in_data_ff, in_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ecsw_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                         fire;
   ecsw_pkg::cfg_type            cfg;
   ecsw_pkg::rsp_type            result;
   logic [ecsw_pkg::TOTAL_W-1:0] total;

   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   ecsw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ecsw_window #(
      .BUCKETS (BUCKETS)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result),
      .total  (total)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A restart always reports an empty window and leaves the total at zero.
   restart_clears_window: assert property (@(posedge clock) disable iff (reset)
      fire && (in_data_ff.kind == ecsw_pkg::KIND_RESTART)
      |=> (rsp_data.window_total == '0) && !rsp_data.bucket_advanced && (total == '0))
      else $error("restart did not clear the window");

   // A tick without a supported count changes nothing.
   unsupported_tick_holds: assert property (@(posedge clock) disable iff (reset)
      fire && (in_data_ff.kind == ecsw_pkg::KIND_TICK) && in_data_ff.device_count[31]
      |=> (rsp_data.window_total == $past(total)) && !rsp_data.bucket_advanced
          && (total == $past(total)))
      else $error("unsupported tick changed the window");

   // The result register only takes a new transaction when its old one has left.
   result_not_overwritten: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("pending result was overwritten");

endmodule

### rtl/ecsw_ram.sv
module ecsw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 60
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

### rtl/ecsw_csr.sv
module ecsw_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ecsw_pkg::PADDR_W-1:0]   paddr,
   input  logic [ecsw_pkg::PDATA_W-1:0]   pwdata,
   output logic [ecsw_pkg::PDATA_W-1:0]   prdata,
   output logic                           pready,
   output ecsw_pkg::cfg_type              cfg
);

   logic [ecsw_pkg::TICK_W-1:0] ticks_per_bucket_ff;
   logic [ecsw_pkg::TICK_W-1:0] ticks_per_bucket_in;
   logic                        write_strobe;

   assign pready       = 1'b1;
   assign write_strobe = psel && penable && pwrite;

   always_comb begin
      ticks_per_bucket_in = ticks_per_bucket_ff;
      if (write_strobe && (paddr[ecsw_pkg::PADDR_W-1:2] == ecsw_pkg::REG_TICKS_PER_BUCKET)) begin
         ticks_per_bucket_in = pwdata[ecsw_pkg::TICK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_bucket_ff <= ecsw_pkg::TICKS_PER_BUCKET_RESET;
      end else begin
         ticks_per_bucket_ff <= ticks_per_bucket_in;
      end
   end

   always_comb begin
      unique case (paddr[ecsw_pkg::PADDR_W-1:2])
         ecsw_pkg::REG_TICKS_PER_BUCKET: begin
            prdata = {{(ecsw_pkg::PDATA_W - ecsw_pkg::TICK_W){1'b0}}, ticks_per_bucket_ff};
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign cfg.ticks_per_bucket = ticks_per_bucket_ff;

endmodule

### rtl/ecsw_window.sv
module ecsw_window #(
   parameter int BUCKETS = 60
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  ecsw_pkg::req_type             item,
   input  ecsw_pkg::cfg_type             cfg,
   output ecsw_pkg::rsp_type             result,
   output logic [ecsw_pkg::TOTAL_W-1:0]  total
);

   localparam int IDX_W = $clog2(BUCKETS);

   function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx);
      logic [IDX_W:0] sum;
      sum = {1'b0, idx} + (IDX_W + 1)'(1);
      if (sum >= (IDX_W + 1)'(BUCKETS)) begin
         return '0;
      end
      return sum[IDX_W-1:0];
   endfunction

   logic [ecsw_pkg::COUNT_W-1:0]  prev_count_ff, prev_count_in;
   logic [IDX_W-1:0]              active_ff, active_in;
   logic [ecsw_pkg::TICK_W-1:0]   tick_ff, tick_in;
   logic [ecsw_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic [ecsw_pkg::BUCKET_W-1:0] active_value_ff, active_value_in;
   logic [BUCKETS-1:0]            valid_ff, valid_in;
   logic                          rvalid_ff, rvalid_in;
   logic                          hit_ff, hit_in;
   logic [ecsw_pkg::BUCKET_W-1:0] hit_data_ff, hit_data_in;

   logic                          is_restart;
   logic                          is_tick;
   logic                          negative;
   logic [ecsw_pkg::COUNT_W-1:0]  count;
   logic [ecsw_pkg::COUNT_W-1:0]  delta;
   logic [ecsw_pkg::TICK_W-1:0]   limit;
   logic [ecsw_pkg::TICK_W-1:0]   tick_inc;
   logic                          advance;
   logic [ecsw_pkg::BUCKET_W-1:0] mem_rdata;
   logic [ecsw_pkg::BUCKET_W-1:0] next_old;
   logic [ecsw_pkg::BUCKET_W-1:0] base;
   logic [ecsw_pkg::BUCKET_W-1:0] room;
   logic [ecsw_pkg::BUCKET_W-1:0] add;
   logic [IDX_W-1:0]              raddr;

   assign negative   = item.device_count[31];
   assign count      = item.device_count[ecsw_pkg::COUNT_W-1:0];
   assign is_restart = fire && (item.kind == ecsw_pkg::KIND_RESTART);
   assign is_tick    = fire && (item.kind == ecsw_pkg::KIND_TICK) && !negative;

   assign delta    = (count > prev_count_ff) ? (count - prev_count_ff) : '0;
   assign limit    = (cfg.ticks_per_bucket == '0) ? ecsw_pkg::TICK_W'(1)
                                                  : cfg.ticks_per_bucket;
   assign tick_inc = tick_ff + ecsw_pkg::TICK_W'(1);
   assign advance  = is_tick && ((tick_inc == '0) || (tick_inc >= limit));

   // The bucket after the active one is prefetched every cycle, so its old value
   // is ready when the ring advances. A write to the same entry is forwarded.
   assign next_old = hit_ff ? hit_data_ff : (rvalid_ff ? mem_rdata : '0);

   assign base = advance ? '0 : active_value_ff;
   assign room = ~base;
   assign add  = ({1'b0, delta} < room) ? {1'b0, delta} : room;

   always_comb begin
      prev_count_in   = prev_count_ff;
      active_in       = active_ff;
      tick_in         = tick_ff;
      total_in        = total_ff;
      active_value_in = active_value_ff;
      valid_in        = valid_ff;
      if (is_restart) begin
         prev_count_in   = negative ? '0 : count;
         active_in       = '0;
         tick_in         = '0;
         total_in        = '0;
         active_value_in = '0;
         valid_in        = '0;
      end else if (is_tick) begin
         prev_count_in   = count;
         tick_in         = advance ? '0 : tick_inc;
         active_in       = advance ? next_index(active_ff) : active_ff;
         active_value_in = base + add;
         total_in        = total_ff
                         - (advance ? {6'b0, next_old} : '0)
                         + {6'b0, add};
         if (advance) begin
            valid_in[active_ff] = 1'b1;
         end
      end
   end

   assign raddr       = next_index(active_in);
   assign rvalid_in   = valid_ff[raddr] && !is_restart;
   assign hit_in      = advance && (active_ff == raddr);
   assign hit_data_in = active_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_count_ff   <= '0;
         active_ff       <= '0;
         tick_ff         <= '0;
         total_ff        <= '0;
         active_value_ff <= '0;
         valid_ff        <= '0;
         rvalid_ff       <= 1'b0;
         hit_ff          <= 1'b0;
      end else begin
         prev_count_ff   <= prev_count_in;
         active_ff       <= active_in;
         tick_ff         <= tick_in;
         total_ff        <= total_in;
         active_value_ff <= active_value_in;
         valid_ff        <= valid_in;
         rvalid_ff       <= rvalid_in;
         hit_ff          <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_data_ff <= hit_data_in;
   end

   ecsw_ram #(
      .WIDTH (ecsw_pkg::BUCKET_W),
      .DEPTH (BUCKETS)
   ) u_bucket_ram (
      .clock      (clock),
      .write_en   (advance),
      .write_addr (active_ff),
      .write_data (active_value_ff),
      .read_addr  (raddr),
      .read_data  (mem_rdata)
   );

   assign result.window_total    = total_in;
   assign result.bucket_advanced = advance;
   assign total                  = total_ff;

endmodule

### tb/sv/event_count_sliding_window_core_test.sv
module event_count_sliding_window_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_SIZE = 60;
   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_ITEMS = 125;
   localparam int NOISE_W = ecsw_pkg::PDATA_W - ecsw_pkg::TICK_W;
   localparam logic [31:0] COUNT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] COUNT_UNSUPPORTED = 32'hFFFF_FFFF;
   localparam logic [ecsw_pkg::TOTAL_W-1:0] BUCKET_FULL = 38'h00_FFFF_FFFF;

   typedef enum logic {ROW_ITEM, ROW_CFG} row_op_type;

   typedef struct packed {
      row_op_type                   op;
      logic                         kind;
      logic [31:0]                  count;
      logic                         typed_in;
      logic [ecsw_pkg::TOTAL_W-1:0] total;
      logic                         advanced;
   } script_row_type;

   localparam int SCRIPT_LEN = 28;

   // A register write row carries the new value in the low byte of count.
   script_row_type script_rows [0:SCRIPT_LEN-1] = '{
      '{ROW_ITEM, ecsw_pkg::KIND_TICK,    32'd0,             1'b1, 38'd0,       1'b0},
      '{ROW_ITEM, ecsw_pkg::KIND_TICK,    32'd100,           1'b1, 38'd100,     1'b0},
      '{ROW_ITEM, ecsw_pkg::KIND_TICK,    COUNT_UNSUPPORTED, 1'b1, 38'd100,     1'b0},
      '{ROW_ITEM, ecsw_pkg::KIND_TICK,    32'd50,            1'b1, 38'd100,     1'b0},
      '{ROW_ITEM, ecsw_pkg::KIND_TICK,    COUNT_MAX,         1'b0, 38'd0,       1'b0},
      '{ROW_ITEM, ecsw_pkg::KIND_TICK,    32'd0,             1'b0, 38'd0,       1'b0},
      '{ROW_ITEM, ecsw_pkg::KIND_TICK,    COUNT_MAX,         1'b1, BUCKET_FULL, 1'b0},
      '{ROW_ITEM, ecsw_pkg::KIND_TICK,    32'd0,             1'b0, 38'd0,       1'b0},
      '{ROW_ITEM, ecsw_pkg::KIND_TICK,    COUNT_MAX,         1'b1, BUCKET_FULL, 1'b0},
      '{ROW_ITEM, ecsw_pkg::KIND_RESTART, 32'd500,           1'b1, 38'd0,       1'b0},
      '{ROW_ITEM, ecsw_pkg::KIND_RESTART, COUNT_UNSUPPORTED, 1'b1, 38'd0,       1'b0},
      '{ROW_CFG,  ecsw_pkg::KIND_TICK,    32'd1,             1'b0, 38'd0,       1'b0},
      '{ROW_ITEM, ecsw_pkg::KIND_TICK,    32'd10,            1'b1, 38'd10,      1'b1},
      '{ROW_ITEM, ecsw_pkg::KIND_TICK,    COUNT_MAX,         1'b0, 38'd0,       1'b0},
      '{ROW_CFG,  ecsw_pkg::KIND_TICK,    32'd0,             1'b0, 38'd0,       1'b0},
      '{ROW_ITEM, ecsw_pkg::KIND_TICK,    COUNT_MAX,         1'b0, 38'd0,       1'b0},
      '{ROW_ITEM, ecsw_pkg::KIND_TICK,    COUNT_UNSUPPORTED, 1'b0, 38'd0,       1'b0},
      '{ROW_CFG,  ecsw_pkg::KIND_TICK,    32'd255,           1'b0, 38'd0,       1'b0},
      '{ROW_ITEM, ecsw_pkg::KIND_TICK,    32'd1000,          1'b0, 38'd0,       1'b0},
      '{ROW_ITEM, ecsw_pkg::KIND_TICK,    32'd2000,          1'b0, 38'd0,       1'b0},
      '{ROW_ITEM, ecsw_pkg::KIND_TICK,    32'd3000,          1'b0, 38'd0,       1'b0},
      '{ROW_CFG,  ecsw_pkg::KIND_TICK,    32'd2,             1'b0, 38'd0,       1'b0},
      '{ROW_ITEM, ecsw_pkg::KIND_TICK,    32'd3500,          1'b0, 38'd0,       1'b0},
      '{ROW_ITEM, ecsw_pkg::KIND_TICK,    32'd4000,          1'b0, 38'd0,       1'b0},
      '{ROW_ITEM, ecsw_pkg::KIND_TICK,    32'd4500,          1'b0, 38'd0,       1'b0},
      '{ROW_ITEM, ecsw_pkg::KIND_RESTART, COUNT_MAX,         1'b1, 38'd0,       1'b0},
      '{ROW_ITEM, ecsw_pkg::KIND_TICK,    COUNT_MAX,         1'b0, 38'd0,       1'b0},
      '{ROW_ITEM, ecsw_pkg::KIND_TICK,    32'd7,             1'b0, 38'd0,       1'b0}
   };

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   ecsw_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   ecsw_pkg::rsp_type rsp_data;
   logic psel;
   logic penable;
   logic pwrite;
   logic [ecsw_pkg::PADDR_W-1:0] paddr;
   logic [ecsw_pkg::PDATA_W-1:0] pwdata;
   logic [ecsw_pkg::PDATA_W-1:0] prdata;
   logic pready;

   // Shadow of the block's window state and its register.
   logic [ecsw_pkg::TICK_W-1:0]   ticks_cfg;
   logic [ecsw_pkg::COUNT_W-1:0]  last_count;
   logic [ecsw_pkg::BUCKET_W-1:0] bucket_mem [0:RING_SIZE-1];
   logic [5:0]                    cur_bucket;
   logic [ecsw_pkg::TICK_W-1:0]   tick_pos;
   logic [ecsw_pkg::TOTAL_W-1:0]  window_sum;

   ecsw_pkg::rsp_type expected_windows [$];
   ecsw_pkg::rsp_type oldest;
   ecsw_pkg::rsp_type predicted;

   // What the driver has on the bus right now, for the monitor to pick up.
   logic                         row_typed_in;
   logic [ecsw_pkg::TOTAL_W-1:0] row_total;
   logic                         row_advanced;

   bit quiet_run;
   int mismatch_count;

   event_count_sliding_window_core #(
      .BUCKETS(RING_SIZE)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic note_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic void clear_window();
      for (int b = 0; b < RING_SIZE; b++) begin
         bucket_mem[b] = '0;
      end
      cur_bucket = '0;
      tick_pos = '0;
      window_sum = '0;
   endfunction

   function automatic ecsw_pkg::rsp_type step_window(input logic k, input logic [31:0] c);
      logic [31:0] delta;
      logic [31:0] room;
      logic [31:0] added;
      logic [8:0]  span;
      logic        moved;
      moved = 1'b0;
      if (k == ecsw_pkg::KIND_RESTART) begin
         clear_window();
         last_count = c[31] ? '0 : c[30:0];
      end else if (!c[31]) begin
         delta = (c[30:0] > last_count) ? {1'b0, c[30:0]} - {1'b0, last_count} : '0;
         last_count = c[30:0];
         // A zero register behaves like one tick per bucket.
         span = (ticks_cfg == '0) ? 9'd1 : {1'b0, ticks_cfg};
         tick_pos = tick_pos + 8'd1;
         if (tick_pos == '0 || {1'b0, tick_pos} >= span) begin
            tick_pos = '0;
            cur_bucket = (cur_bucket == 6'(RING_SIZE - 1)) ? '0 : cur_bucket + 6'd1;
            window_sum = window_sum - {6'b0, bucket_mem[cur_bucket]};
            bucket_mem[cur_bucket] = '0;
            moved = 1'b1;
         end
         // The bucket saturates, and only what fits enters the total.
         room = 32'hFFFF_FFFF - bucket_mem[cur_bucket];
         added = (delta < room) ? delta : room;
         bucket_mem[cur_bucket] = bucket_mem[cur_bucket] + added;
         window_sum = window_sum + {6'b0, added};
      end
      return '{window_total: window_sum, bucket_advanced: moved};
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_window();
         last_count = '0;
         ticks_cfg <= ecsw_pkg::TICKS_PER_BUCKET_RESET;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_windows.size() == 0) begin
               note_mismatch("unexpected result", 64'(rsp_data), '0);
            end else begin
               oldest = expected_windows.pop_front();
               if (rsp_data.window_total !== oldest.window_total) begin
                  note_mismatch("window_total", 64'(rsp_data.window_total),
                                64'(oldest.window_total));
               end
               if (rsp_data.bucket_advanced !== oldest.bucket_advanced) begin
                  note_mismatch("bucket_advanced", 64'(rsp_data.bucket_advanced),
                                64'(oldest.bucket_advanced));
               end
            end
         end
         if (req_valid && req_ready) begin
            predicted = step_window(req_data.kind, req_data.device_count);
            if (row_typed_in) begin
               expected_windows.push_back('{window_total: row_total,
                                            bucket_advanced: row_advanced});
            end else begin
               expected_windows.push_back(predicted);
            end
         end
         if (psel && penable && pready) begin
            if (pwrite) begin
               ticks_cfg <= pwdata[ecsw_pkg::TICK_W-1:0];
            end else if (prdata !== {{NOISE_W{1'b0}}, ticks_cfg}) begin
               note_mismatch("ticks_per_bucket readback", 64'(prdata), 64'(ticks_cfg));
            end
         end
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= quiet_run || ($urandom_range(0, 99) >= 7);
      end
   end

   initial begin : watchdog
      int stalled;
      stalled = 0;
      do begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (psel && penable && pready)) begin
            stalled = 0;
         end else begin
            stalled++;
         end
      end while (stalled < STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // Called and returning at a falling edge; valid stays up between back-to-back items.
   task automatic drive_item(input logic k, input logic [31:0] c, input logic typed_in,
                             input logic [ecsw_pkg::TOTAL_W-1:0] tot, input logic adv);
      if (!quiet_run && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{kind: k, device_count: c};
      row_typed_in = typed_in;
      row_total = tot;
      row_advanced = adv;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (expected_windows.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input logic is_write, input logic [ecsw_pkg::TICK_W-1:0] value);
      logic [NOISE_W-1:0] noise;
      noise = NOISE_W'($urandom());
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= {ecsw_pkg::REG_TICKS_PER_BUCKET, 2'b00};
      pwdata <= {noise, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [ecsw_pkg::TICK_W-1:0]  phase_cfg [0:7];
      logic [ecsw_pkg::COUNT_W-1:0] stim_count;
      logic [31:0]                  incr;
      logic [31:0]                  count_word;
      logic                         kind_bit;
      int                           pick;
      int                           item_no;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      row_typed_in = 1'b0;
      row_total = '0;
      row_advanced = 1'b0;
      quiet_run = 1'b0;
      mismatch_count = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reads back the reset value of the register.
      csr_access(1'b0, '0);

      foreach (script_rows[i]) begin
         if (script_rows[i].op == ROW_CFG) begin
            wait_quiet();
            csr_access(1'b1, script_rows[i].count[ecsw_pkg::TICK_W-1:0]);
            csr_access(1'b0, '0);
         end else begin
            drive_item(script_rows[i].kind, script_rows[i].count, script_rows[i].typed_in,
                       script_rows[i].total, script_rows[i].advanced);
         end
      end

      phase_cfg = '{8'd1, 8'd255, 8'd2, 8'd0, 8'd0, 8'd30, 8'd1, 8'd0};
      phase_cfg[4] = ecsw_pkg::TICK_W'($urandom_range(3, 12));
      phase_cfg[7] = ecsw_pkg::TICK_W'($urandom_range(3, 12));
      stim_count = '0;
      item_no = 0;
      foreach (phase_cfg[p]) begin
         // Each phase starts from a drained block, so the register change is clean.
         wait_quiet();
         csr_access(1'b1, phase_cfg[p]);
         csr_access(1'b0, '0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            quiet_run = (item_no >= 250 && item_no < 500);
            pick = $urandom_range(0, 99);
            kind_bit = ecsw_pkg::KIND_TICK;
            if (pick < 65) begin
               incr = $urandom_range(0, 2000);
               if ({1'b0, stim_count} > COUNT_MAX - incr) begin
                  stim_count = ecsw_pkg::COUNT_W'($urandom_range(0, 1000));
               end else begin
                  stim_count = stim_count + incr[ecsw_pkg::COUNT_W-1:0];
               end
               count_word = {1'b0, stim_count};
            end else if (pick < 75) begin
               stim_count = ecsw_pkg::COUNT_W'($urandom());
               count_word = {1'b0, stim_count};
            end else if (pick < 80) begin
               stim_count = ecsw_pkg::COUNT_W'($urandom_range(0, 15));
               count_word = {1'b0, stim_count};
            end else if (pick < 85) begin
               stim_count = COUNT_MAX[ecsw_pkg::COUNT_W-1:0];
               count_word = COUNT_MAX;
            end else if (pick < 92) begin
               count_word = COUNT_UNSUPPORTED;
            end else if (pick < 97) begin
               kind_bit = ecsw_pkg::KIND_RESTART;
               stim_count = ecsw_pkg::COUNT_W'($urandom());
               count_word = {1'b0, stim_count};
            end else begin
               kind_bit = ecsw_pkg::KIND_RESTART;
               stim_count = '0;
               count_word = COUNT_UNSUPPORTED;
            end
            drive_item(kind_bit, count_word, 1'b0, '0, 1'b0);
            item_no++;
         end
      end
      quiet_run = 1'b0;

      wait_quiet();
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### sim.f
rtl/ecsw_pkg.sv
rtl/ecsw_ram.sv
rtl/ecsw_csr.sv
rtl/ecsw_window.sv
rtl/event_count_sliding_window_core.sv
tb/sv/event_count_sliding_window_core_test.sv
